### design/gsmr_pkg.sv
// ----------------------------------------------------------------------------
// gsmr_pkg: shared types and constants for the gas source mux with ramp
// Holds request and source codes, register indexes, reset levels, the clamp
// function and the request struct for the ramp interpolation unit.
// ----------------------------------------------------------------------------
package gsmr_pkg;

    localparam int LEVEL_W = 12;
    localparam int WIDE_W  = 16;
    localparam int CODE_W  = 3;
    localparam int CFG_IDX_W = 2;

    // request codes
    localparam logic [CODE_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [CODE_W-1:0] REQ_UPDATE = 3'd1;
    localparam logic [CODE_W-1:0] REQ_UART   = 3'd2;
    localparam logic [CODE_W-1:0] REQ_RAMP   = 3'd3;
    localparam logic [CODE_W-1:0] REQ_SCENE  = 3'd4;
    localparam logic [CODE_W-1:0] REQ_SOURCE = 3'd5;

    // source codes
    localparam logic [CODE_W-1:0] SRC_SENSOR = 3'd0;
    localparam logic [CODE_W-1:0] SRC_POT    = 3'd1;
    localparam logic [CODE_W-1:0] SRC_LOOP   = 3'd2;
    localparam logic [CODE_W-1:0] SRC_SCENE  = 3'd3;
    localparam logic [CODE_W-1:0] SRC_UART   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAS_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_SOURCE = 2'd2;

    localparam logic [LEVEL_W-1:0] RESET_LEVEL     = 12'd320;
    localparam logic [LEVEL_W-1:0] WEAK_LOOP       = 12'd20;
    localparam logic [LEVEL_W-1:0] GAS_LIMIT_RESET = 12'd4095;
    localparam logic               FALLBACK_RESET  = 1'b1;
    localparam logic [CODE_W-1:0]  SOURCE_RESET    = SRC_SENSOR;
    localparam logic [WIDE_W-1:0]  RAMP_LEN_RESET  = 16'd1;

    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] from;
        logic [LEVEL_W-1:0] to;
        logic [WIDE_W-1:0]  count;
        logic [WIDE_W-1:0]  length;
    } t_ramp_req;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } t_ramp_rsp;

    function automatic logic [LEVEL_W-1:0] f_clamp(input logic [WIDE_W-1:0] v,
                                                   input logic [LEVEL_W-1:0] lim);
        return (v > {{(WIDE_W-LEVEL_W){1'b0}}, lim}) ? lim : v[LEVEL_W-1:0];
    endfunction

endpackage

### design/gas_source_mux_with_ramp_top.sv
// ----------------------------------------------------------------------------
// gas_source_mux_with_ramp_top: gas source selector with timed UART ramp
// Selects and clamps the gas value, holds the UART and scene levels and runs
// a linear ramp on the UART level, one step per tick beat.
// ----------------------------------------------------------------------------
// Each input beat yields exactly one output beat showing the state after that
// request. Update, set and source beats go from accept to the output beat
// through the state register alone. A tick beat that advances a running ramp
// waits on the interpolation unit, which loads, multiplies, runs the restoring
// divide (one quotient bit per cycle) and then reports.
// The block takes one beat at a time: input stall stays high from accept until
// the output beat is taken. The configuration port is always ready; write it
// only while the block is idle. gas_limit clamps every value stored or picked,
// loop_fallback_enable swaps a weak loopback reading (below 20) for the DAC
// setpoint when that is above 20. reset_source is accepted but only takes its
// reset value into the source selection, which is the sensor.
// ----------------------------------------------------------------------------
module gas_source_mux_with_ramp_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gsmr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gsmr_pkg::LEVEL_W-1:0]          i_cfg_data,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [gsmr_pkg::CODE_W-1:0]           i_req_type,
    input  logic [gsmr_pkg::LEVEL_W-1:0]          i_sensor_sample,
    input  logic [gsmr_pkg::LEVEL_W-1:0]          i_pot_sample,
    input  logic [gsmr_pkg::LEVEL_W-1:0]          i_loop_sample,
    input  logic [gsmr_pkg::LEVEL_W-1:0]          i_dac_setpoint,
    input  logic [gsmr_pkg::WIDE_W-1:0]           i_new_value,
    input  logic [gsmr_pkg::WIDE_W-1:0]           i_ramp_target,
    input  logic [gsmr_pkg::WIDE_W-1:0]           i_ramp_seconds,
    input  logic [gsmr_pkg::CODE_W-1:0]           i_source_code,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [gsmr_pkg::LEVEL_W-1:0]          o_gas_value,
    output logic [gsmr_pkg::LEVEL_W-1:0]          o_uart_level,
    output logic [gsmr_pkg::LEVEL_W-1:0]          o_scene_level,
    output logic [gsmr_pkg::CODE_W-1:0]           o_active_source,
    output logic                                  o_ramp_running
);
    import gsmr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [LEVEL_W-1:0] r_gas_limit;
    logic               r_fallback_en;

    logic [CODE_W-1:0]  r_source_sel, n_source_sel;
    logic [LEVEL_W-1:0] r_uart, n_uart;
    logic [LEVEL_W-1:0] r_scene, n_scene;
    logic [LEVEL_W-1:0] r_effective, n_effective;
    logic               r_ramp_on, n_ramp_on;
    logic [LEVEL_W-1:0] r_ramp_from, n_ramp_from;
    logic [LEVEL_W-1:0] r_ramp_to, n_ramp_to;
    logic [WIDE_W-1:0]  r_ramp_len, n_ramp_len;
    logic [WIDE_W-1:0]  r_ramp_cnt, n_ramp_cnt;

    logic               in_accept;
    logic [LEVEL_W-1:0] sensor_c;
    logic [LEVEL_W-1:0] pot_c;
    logic [LEVEL_W-1:0] loop_raw;
    logic [LEVEL_W-1:0] loop_c;
    logic [LEVEL_W-1:0] pick;
    logic [LEVEL_W-1:0] new_c;
    t_ramp_req          ramp_req;
    t_ramp_rsp          ramp_rsp;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;

    // configuration registers; reset_source needs no storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gas_limit   <= GAS_LIMIT_RESET;
            r_fallback_en <= FALLBACK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GAS_LIMIT:    r_gas_limit   <= i_cfg_data;
                CFG_FALLBACK_EN:  r_fallback_en <= i_cfg_data[0];
                CFG_RESET_SOURCE: r_gas_limit   <= r_gas_limit;
                default:          r_gas_limit   <= r_gas_limit;
            endcase
        end
    end

    // sample path: clamp each reading, swap in the setpoint for a weak loopback
    assign sensor_c = f_clamp({4'b0, i_sensor_sample}, r_gas_limit);
    assign pot_c    = f_clamp({4'b0, i_pot_sample}, r_gas_limit);
    assign loop_raw = (r_fallback_en && (i_loop_sample < WEAK_LOOP)
                       && (i_dac_setpoint > WEAK_LOOP)) ? i_dac_setpoint : i_loop_sample;
    assign loop_c   = f_clamp({4'b0, loop_raw}, r_gas_limit);
    assign new_c    = f_clamp(i_new_value, r_gas_limit);

    always_comb begin
        case (r_source_sel)
            SRC_POT:   pick = pot_c;
            SRC_LOOP:  pick = loop_c;
            SRC_SCENE: pick = f_clamp({4'b0, r_scene}, r_gas_limit);
            SRC_UART:  pick = f_clamp({4'b0, r_uart}, r_gas_limit);
            default:   pick = sensor_c;
        endcase
    end

    // request decode and sequencer
    always_comb begin
        n_state      = r_state;
        n_source_sel = r_source_sel;
        n_uart       = r_uart;
        n_scene      = r_scene;
        n_effective  = r_effective;
        n_ramp_on    = r_ramp_on;
        n_ramp_from  = r_ramp_from;
        n_ramp_to    = r_ramp_to;
        n_ramp_len   = r_ramp_len;
        n_ramp_cnt   = r_ramp_cnt;

        ramp_req.start  = 1'b0;
        ramp_req.from   = r_ramp_from;
        ramp_req.to     = r_ramp_to;
        ramp_req.count  = r_ramp_cnt + 1'b1;
        ramp_req.length = r_ramp_len;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_OUT;
                    case (i_req_type)
                        REQ_TICK: begin
                            if (r_ramp_on) begin
                                if (r_ramp_cnt >= r_ramp_len) begin
                                    // land exactly on the end value and stop
                                    n_uart    = r_ramp_to;
                                    n_ramp_on = 1'b0;
                                end else begin
                                    // advance one step and interpolate
                                    n_ramp_cnt     = r_ramp_cnt + 1'b1;
                                    ramp_req.start = 1'b1;
                                    n_state        = S_WAIT;
                                end
                            end
                        end
                        REQ_UPDATE: n_effective = pick;
                        REQ_UART: begin
                            n_uart       = new_c;
                            n_source_sel = SRC_UART;
                        end
                        REQ_RAMP: begin
                            n_ramp_from  = new_c;
                            n_ramp_to    = f_clamp(i_ramp_target, r_gas_limit);
                            n_ramp_len   = (i_ramp_seconds == '0) ? RAMP_LEN_RESET
                                                                  : i_ramp_seconds;
                            n_ramp_cnt   = '0;
                            n_ramp_on    = 1'b1;
                            n_source_sel = SRC_UART;
                            n_uart       = new_c;
                        end
                        REQ_SCENE:  n_scene      = new_c;
                        REQ_SOURCE: n_source_sel = i_source_code;
                        default:    n_state      = S_OUT;
                    endcase
                end
            end
            S_WAIT: begin
                if (ramp_rsp.done) begin
                    n_uart  = ramp_rsp.level;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_source_sel <= SOURCE_RESET;
            r_uart       <= RESET_LEVEL;
            r_scene      <= RESET_LEVEL;
            r_effective  <= RESET_LEVEL;
            r_ramp_on    <= 1'b0;
            r_ramp_from  <= '0;
            r_ramp_to    <= '0;
            r_ramp_len   <= RAMP_LEN_RESET;
            r_ramp_cnt   <= '0;
        end else begin
            r_state      <= n_state;
            r_source_sel <= n_source_sel;
            r_uart       <= n_uart;
            r_scene      <= n_scene;
            r_effective  <= n_effective;
            r_ramp_on    <= n_ramp_on;
            r_ramp_from  <= n_ramp_from;
            r_ramp_to    <= n_ramp_to;
            r_ramp_len   <= n_ramp_len;
            r_ramp_cnt   <= n_ramp_cnt;
        end
    end

    gsmr_ramp_div u_ramp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ramp_req),
        .o_rsp   (ramp_rsp)
    );

    // state holds while the output beat waits, so the payload reads it directly
    assign o_gas_value       = r_effective;
    assign o_uart_level      = r_uart;
    assign o_scene_level     = r_scene;
    assign o_active_source   = r_source_sel;
    assign o_ramp_running    = r_ramp_on;

endmodule

### design/gsmr_ramp_div.sv
// ----------------------------------------------------------------------------
// gsmr_ramp_div: ramp interpolation unit
// Computes from + (to - from) * count / length, truncated toward zero, with
// a multiply step and a restoring divide step shared by all quotient bits,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gsmr_ramp_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gsmr_pkg::t_ramp_req i_req,
    output gsmr_pkg::t_ramp_rsp o_rsp
);
    import gsmr_pkg::*;

    localparam int PROD_W = LEVEL_W + WIDE_W;
    localparam int STEP_W = $clog2(LEVEL_W);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]         r_phase;
    logic [STEP_W-1:0]  r_step;
    logic               r_neg;
    logic [LEVEL_W-1:0] r_mag;
    logic [LEVEL_W-1:0] r_from;
    logic [WIDE_W-1:0]  r_count;
    logic [WIDE_W-1:0]  r_length;
    logic [WIDE_W-1:0]  r_rem;
    logic [LEVEL_W-1:0] r_quo;   // low product bits shift out, quotient bits shift in

    logic [PROD_W-1:0]  prod;
    logic [WIDE_W:0]    rem_sh;
    logic               q_bit;
    logic [WIDE_W:0]    rem_sub;

    // quotient never exceeds |to - from|, so the top product bits start below length
    assign prod    = PROD_W'(r_mag) * PROD_W'(r_count);
    assign rem_sh  = {r_rem, r_quo[LEVEL_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_length});
    assign rem_sub = rem_sh - {1'b0, r_length};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_step  <= '0;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_req.start) begin
                        r_phase <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    r_phase <= PH_DIV;
                    r_step  <= '0;
                end
                PH_DIV: begin
                    if (r_step == STEP_W'(LEVEL_W - 1)) begin
                        r_phase <= PH_DONE;
                    end
                    r_step <= r_step + 1'b1;
                end
                PH_DONE: r_phase <= PH_IDLE;
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE && i_req.start) begin
            r_neg    <= (i_req.to < i_req.from);
            r_mag    <= (i_req.to < i_req.from) ? (i_req.from - i_req.to)
                                                : (i_req.to - i_req.from);
            r_from   <= i_req.from;
            r_count  <= i_req.count;
            r_length <= i_req.length;
        end
        if (r_phase == PH_MUL) begin
            r_rem <= prod[PROD_W-1:LEVEL_W];
            r_quo <= prod[LEVEL_W-1:0];
        end
        if (r_phase == PH_DIV) begin
            r_rem <= q_bit ? rem_sub[WIDE_W-1:0] : rem_sh[WIDE_W-1:0];
            r_quo <= {r_quo[LEVEL_W-2:0], q_bit};
        end
    end

    assign o_rsp.done  = (r_phase == PH_DONE);
    assign o_rsp.level = r_neg ? (r_from - r_quo) : (r_from + r_quo);

endmodule

### design/gsmr_checker.sv
// ----------------------------------------------------------------------------
// gsmr_checker: port-level checks for the gas source mux with ramp
// Watches the top-level ports for output holding, one-beat-at-a-time flow and
// the source and ramp effects of requests.
// ----------------------------------------------------------------------------
module gsmr_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic [gsmr_pkg::CODE_W-1:0]        i_req_type,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [gsmr_pkg::LEVEL_W-1:0]       o_gas_value,
    input logic [gsmr_pkg::LEVEL_W-1:0]       o_uart_level,
    input logic [gsmr_pkg::CODE_W-1:0]        o_active_source,
    input logic                               o_ramp_running
);
    import gsmr_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_gas_value)
            && $stable(o_uart_level) && $stable(o_active_source))
        else $error("output beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result waits");

    a_uart_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_req_type == REQ_UART || i_req_type == REQ_RAMP)
            |=> o_active_source == SRC_UART)
        else $error("set uart or ramp start did not select uart");

    a_ramp_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_ramp_running) |-> $past(in_acc && i_req_type == REQ_RAMP))
        else $error("ramp started without a ramp request");

endmodule

bind gas_source_mux_with_ramp_top gsmr_checker u_gsmr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_req_type        (i_req_type),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_gas_value       (o_gas_value),
    .o_uart_level      (o_uart_level),
    .o_active_source   (o_active_source),
    .o_ramp_running    (o_ramp_running)
);

### test/gas_source_mux_with_ramp_top_test.sv
// ----------------------------------------------------------------------------
// gas_source_mux_with_ramp_top_test: self-checking bench for the gas source mux
// Sends request beats under random sender gaps and receiver stalls. A
// behavioral copy of the selector, clamp and ramp interpolation predicts each
// status beat, and every status beat is checked field by field. Several
// register settings are swept, the extremes among them.
// ----------------------------------------------------------------------------
module gas_source_mux_with_ramp_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gsmr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // idle cycles before giving up
    localparam int SETTLE_CYCLES  = 20;     // quiet time after the last status beat drains
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 10;
    localparam int BURST_ITEMS    = 105;

    // request codes the block treats as no-ops, and a source code it maps to
    // the sensor
    localparam logic [CODE_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [CODE_W-1:0] REQ_SPARE_HI = 3'd7;
    localparam logic [CODE_W-1:0] SRC_UNUSED   = 3'd7;

    typedef struct {
        logic [CODE_W-1:0]  req_type;
        logic [LEVEL_W-1:0] sensor_sample;
        logic [LEVEL_W-1:0] pot_sample;
        logic [LEVEL_W-1:0] loop_sample;
        logic [LEVEL_W-1:0] dac_setpoint;
        logic [WIDE_W-1:0]  new_value;
        logic [WIDE_W-1:0]  ramp_target;
        logic [WIDE_W-1:0]  ramp_seconds;
        logic [CODE_W-1:0]  source_code;
    } t_gas_request;

    typedef struct {
        logic [LEVEL_W-1:0] gas_value;
        logic [LEVEL_W-1:0] uart_level;
        logic [LEVEL_W-1:0] scene_level;
        logic [CODE_W-1:0]  active_source;
        logic               ramp_running;
    } t_gas_status;

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEVEL_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [CODE_W-1:0]    req_type;
    logic [LEVEL_W-1:0]   sensor_sample;
    logic [LEVEL_W-1:0]   pot_sample;
    logic [LEVEL_W-1:0]   loop_sample;
    logic [LEVEL_W-1:0]   dac_setpoint;
    logic [WIDE_W-1:0]    new_value;
    logic [WIDE_W-1:0]    ramp_target;
    logic [WIDE_W-1:0]    ramp_seconds;
    logic [CODE_W-1:0]    source_code;
    logic                 out_valid;
    logic                 out_stall;
    logic [LEVEL_W-1:0]   gas_value;
    logic [LEVEL_W-1:0]   uart_level;
    logic [LEVEL_W-1:0]   scene_level;
    logic [CODE_W-1:0]    active_source;
    logic                 ramp_running;

    gas_source_mux_with_ramp_top uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_req_type        (req_type),
        .i_sensor_sample   (sensor_sample),
        .i_pot_sample      (pot_sample),
        .i_loop_sample     (loop_sample),
        .i_dac_setpoint    (dac_setpoint),
        .i_new_value       (new_value),
        .i_ramp_target     (ramp_target),
        .i_ramp_seconds    (ramp_seconds),
        .i_source_code     (source_code),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_gas_value       (gas_value),
        .o_uart_level      (uart_level),
        .o_scene_level     (scene_level),
        .o_active_source   (active_source),
        .o_ramp_running    (ramp_running)
    );

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    t_gas_status pending_status[$];   // predicted status beats, oldest first
    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          items_sent     = 0;
    int          settings_run   = 1;  // the reset setting counts
    int          ramps_finished = 0;
    int          idle_cycles    = 0;
    logic        quiet_mode     = 1'b0;  // no gaps and no stalls while set

    // ------------------------------------------------------------------------
    // Behavioral copy of the block: registers and state
    // ------------------------------------------------------------------------
    logic [LEVEL_W-1:0] lim_level;
    logic               fallback_on;
    logic [CODE_W-1:0]  boot_source;   // stored, but only its reset value is ever loaded
    logic [CODE_W-1:0]  sel_source;
    logic [LEVEL_W-1:0] uart_lvl;
    logic [LEVEL_W-1:0] scene_lvl;
    logic [LEVEL_W-1:0] eff_lvl;
    logic               ramp_on_flag;
    logic [LEVEL_W-1:0] ramp_from_lvl;
    logic [LEVEL_W-1:0] ramp_to_lvl;
    logic [WIDE_W-1:0]  ramp_len;
    logic [WIDE_W-1:0]  ramp_elapsed;

    function automatic void reset_model();
        lim_level     = GAS_LIMIT_RESET;
        fallback_on   = FALLBACK_RESET;
        boot_source   = SOURCE_RESET;
        sel_source    = SOURCE_RESET;
        uart_lvl      = RESET_LEVEL;
        scene_lvl     = RESET_LEVEL;
        eff_lvl       = RESET_LEVEL;
        ramp_on_flag  = 1'b0;
        ramp_from_lvl = '0;
        ramp_to_lvl   = '0;
        ramp_len      = RAMP_LEN_RESET;
        ramp_elapsed  = '0;
    endfunction

    function automatic logic [LEVEL_W-1:0] limit_level(input logic [WIDE_W-1:0] v);
        if (int'(v) > int'(lim_level))
            return lim_level;
        return v[LEVEL_W-1:0];
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [LEVEL_W-1:0] data);
        case (idx)
            CFG_GAS_LIMIT:    lim_level   = data;
            CFG_FALLBACK_EN:  fallback_on = data[0];
            CFG_RESET_SOURCE: boot_source = data[CODE_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the copy by one request and return the status beat it implies.
    function automatic t_gas_status advance_model(input t_gas_request rq);
        t_gas_status        st;
        logic [LEVEL_W-1:0] sensor_lvl;
        logic [LEVEL_W-1:0] pot_lvl;
        logic [LEVEL_W-1:0] loop_lvl;
        logic [LEVEL_W-1:0] pick;
        logic [WIDE_W-1:0]  secs;
        int                 delta;
        int                 level;

        case (rq.req_type)
            REQ_TICK: begin
                if (ramp_on_flag) begin
                    if (ramp_elapsed >= ramp_len) begin
                        uart_lvl     = ramp_to_lvl;
                        ramp_on_flag = 1'b0;
                        ramps_finished++;
                    end else begin
                        ramp_elapsed = ramp_elapsed + 1'b1;
                        delta = int'(ramp_to_lvl) - int'(ramp_from_lvl);
                        level = int'(ramp_from_lvl)
                              + (delta * int'(ramp_elapsed)) / int'(ramp_len);
                        uart_lvl = level[LEVEL_W-1:0];
                    end
                end
            end
            REQ_UPDATE: begin
                sensor_lvl = limit_level(WIDE_W'(rq.sensor_sample));
                pot_lvl    = limit_level(WIDE_W'(rq.pot_sample));
                loop_lvl   = rq.loop_sample;
                if (fallback_on && loop_lvl < WEAK_LOOP && rq.dac_setpoint > WEAK_LOOP)
                    loop_lvl = rq.dac_setpoint;
                loop_lvl = limit_level(WIDE_W'(loop_lvl));
                case (sel_source)
                    SRC_POT:   pick = pot_lvl;
                    SRC_LOOP:  pick = loop_lvl;
                    SRC_SCENE: pick = scene_lvl;
                    SRC_UART:  pick = uart_lvl;
                    default:   pick = sensor_lvl;
                endcase
                eff_lvl = limit_level(WIDE_W'(pick));
            end
            REQ_UART: begin
                uart_lvl   = limit_level(rq.new_value);
                sel_source = SRC_UART;
            end
            REQ_RAMP: begin
                secs = (rq.ramp_seconds == '0) ? RAMP_LEN_RESET : rq.ramp_seconds;
                ramp_from_lvl = limit_level(rq.new_value);
                ramp_to_lvl   = limit_level(rq.ramp_target);
                ramp_len      = secs;
                ramp_elapsed  = '0;
                ramp_on_flag  = 1'b1;
                sel_source    = SRC_UART;
                uart_lvl      = ramp_from_lvl;
            end
            REQ_SCENE:  scene_lvl  = limit_level(rq.new_value);
            REQ_SOURCE: sel_source = rq.source_code;
            default: ;
        endcase

        st.gas_value       = eff_lvl;
        st.uart_level      = uart_lvl;
        st.scene_level     = scene_lvl;
        st.active_source   = sel_source;
        st.ramp_running    = ramp_on_flag;
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, watchdog, receiver stall and result checking
    // ------------------------------------------------------------------------
    initial begin : clock_gen
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Count cycles in which neither channel moves a beat; give up at the limit.
    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d status beats outstanding",
                     idle_cycles, pending_status.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly short stalls, a few long ones, with stall-free runs in between.
    function automatic int pick_gap();
        int r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial begin : result_backpressure
        int hold;
        out_stall = 1'b0;
        forever begin
            repeat ($urandom_range(1, 30)) begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
            hold = pick_gap();
            repeat (hold) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    function automatic void compare_field(input string field,
                                          input logic [WIDE_W-1:0] want_v,
                                          input logic [WIDE_W-1:0] got_v);
        if (got_v !== want_v) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("status beat %0d: %s expected %0d, got %0d",
                         results_seen, field, want_v, got_v);
        end
    endfunction

    // Take each status beat and hold it against the oldest prediction.
    always @(posedge clk) begin : status_monitor
        t_gas_status want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_status.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("status beat %0d arrived with no request behind it",
                             results_seen);
            end else begin
                want = pending_status.pop_front();
                compare_field("gas_value", WIDE_W'(want.gas_value), WIDE_W'(gas_value));
                compare_field("uart_level", WIDE_W'(want.uart_level), WIDE_W'(uart_level));
                compare_field("scene_level", WIDE_W'(want.scene_level),
                              WIDE_W'(scene_level));
                compare_field("active_source", WIDE_W'(want.active_source),
                              WIDE_W'(active_source));
                compare_field("ramp_running", WIDE_W'(want.ramp_running),
                              WIDE_W'(ramp_running));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Present one request beat, hold it until taken, then idle for a random gap.
    // Valid stays high when the gap is zero so back-to-back beats never glitch.
    task automatic send_request(input t_gas_request rq);
        int gap;
        @(negedge clk);
        in_valid      <= 1'b1;
        req_type      <= rq.req_type;
        sensor_sample <= rq.sensor_sample;
        pot_sample    <= rq.pot_sample;
        loop_sample   <= rq.loop_sample;
        dac_setpoint  <= rq.dac_setpoint;
        new_value     <= rq.new_value;
        ramp_target   <= rq.ramp_target;
        ramp_seconds  <= rq.ramp_seconds;
        source_code   <= rq.source_code;
        do @(posedge clk); while (in_stall);
        pending_status.push_back(advance_model(rq));
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid, drain every outstanding status beat, then let a ramp step settle.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [LEVEL_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_gas_request make_request(input logic [CODE_W-1:0] code);
        t_gas_request rq;
        rq.req_type      = code;
        rq.sensor_sample = '0;
        rq.pot_sample    = '0;
        rq.loop_sample   = '0;
        rq.dac_setpoint  = '0;
        rq.new_value     = '0;
        rq.ramp_target   = '0;
        rq.ramp_seconds  = '0;
        rq.source_code   = SRC_SENSOR;
        return rq;
    endfunction

    // Random payload on every field; weak loopback readings and short ramps
    // are favored so the fallback and ramp completion are reached often.
    function automatic t_gas_request random_request();
        t_gas_request rq;
        int           r;
        r = $urandom_range(0, 99);
        if (r < 30)      rq.req_type = REQ_TICK;
        else if (r < 50) rq.req_type = REQ_UPDATE;
        else if (r < 57) rq.req_type = REQ_UART;
        else if (r < 67) rq.req_type = REQ_RAMP;
        else if (r < 77) rq.req_type = REQ_SCENE;
        else if (r < 94) rq.req_type = REQ_SOURCE;
        else             rq.req_type = ($urandom_range(0, 1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
        rq.sensor_sample = LEVEL_W'($urandom_range(0, 4095));
        rq.pot_sample    = LEVEL_W'($urandom_range(0, 4095));
        rq.loop_sample   = LEVEL_W'(($urandom_range(0, 9) < 3) ? $urandom_range(0, 25)
                                                               : $urandom_range(0, 4095));
        rq.dac_setpoint  = LEVEL_W'(($urandom_range(0, 9) < 3) ? $urandom_range(0, 25)
                                                               : $urandom_range(0, 4095));
        rq.new_value     = WIDE_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535)
                                                               : $urandom_range(0, 4095));
        rq.ramp_target   = WIDE_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535)
                                                               : $urandom_range(0, 4095));
        r = $urandom_range(0, 99);
        if (r < 70)      rq.ramp_seconds = WIDE_W'($urandom_range(0, 6));
        else if (r < 95) rq.ramp_seconds = WIDE_W'($urandom_range(7, 40));
        else             rq.ramp_seconds = WIDE_W'($urandom_range(0, 65535));
        rq.source_code   = CODE_W'($urandom_range(0, 7));
        return rq;
    endfunction

    // Random beats; a short ramp is usually followed by enough ticks to finish.
    task automatic run_random_burst(input int count);
        t_gas_request rq;
        int           sent;
        sent = 0;
        while (sent < count) begin
            rq = random_request();
            send_request(rq);
            sent++;
            if (rq.req_type == REQ_RAMP && rq.ramp_seconds < 8 && $urandom_range(0, 3) != 0) begin
                repeat (int'(rq.ramp_seconds) + $urandom_range(1, 3)) begin
                    rq = random_request();
                    rq.req_type = REQ_TICK;
                    send_request(rq);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Tick with no ramp and the spare request codes must leave the reset state.
    task automatic test_reset_state();
        send_request(make_request(REQ_TICK));
        send_request(make_request(REQ_SPARE_LO));
        send_request(make_request(REQ_SPARE_HI));
    endtask

    task automatic test_source_select();
        t_gas_request rq;

        // sensor at full scale, everything else at zero
        rq = make_request(REQ_UPDATE);
        rq.sensor_sample = 12'd4095;
        send_request(rq);

        rq = make_request(REQ_SOURCE);
        rq.source_code = SRC_POT;
        send_request(rq);
        rq = make_request(REQ_UPDATE);
        rq.pot_sample = 12'd4095;
        send_request(rq);

        // loopback: weak reading replaced, then both thresholds on the edge
        rq = make_request(REQ_SOURCE);
        rq.source_code = SRC_LOOP;
        send_request(rq);
        rq = make_request(REQ_UPDATE);
        rq.loop_sample  = 12'd5;
        rq.dac_setpoint = 12'd4095;
        send_request(rq);
        rq.loop_sample  = 12'd19;
        rq.dac_setpoint = 12'd20;
        send_request(rq);
        rq.loop_sample  = 12'd20;
        rq.dac_setpoint = 12'd21;
        send_request(rq);

        // scene value above the 12-bit range gets clamped
        rq = make_request(REQ_SCENE);
        rq.new_value = 16'hFFFF;
        send_request(rq);
        rq = make_request(REQ_SOURCE);
        rq.source_code = SRC_SCENE;
        send_request(rq);
        send_request(make_request(REQ_UPDATE));

        // writing the serial value moves the source to UART
        rq = make_request(REQ_UART);
        rq.new_value = 16'd0;
        send_request(rq);
        send_request(make_request(REQ_UPDATE));

        // an unused source code is stored but reads the sensor
        rq = make_request(REQ_SOURCE);
        rq.source_code = SRC_UNUSED;
        send_request(rq);
        rq = make_request(REQ_UPDATE);
        rq.sensor_sample = 12'd1234;
        send_request(rq);
    endtask

    task automatic test_ramp_sequences();
        t_gas_request rq;

        // falling ramp: the negative step truncates toward zero, and the ramp
        // reports running for one tick after it reaches the end
        rq = make_request(REQ_RAMP);
        rq.new_value    = 16'd10;
        rq.ramp_target  = 16'd0;
        rq.ramp_seconds = 16'd3;
        send_request(rq);
        repeat (4) send_request(make_request(REQ_TICK));

        // zero duration runs as one second; target clamps to the limit
        rq = make_request(REQ_RAMP);
        rq.new_value    = 16'd0;
        rq.ramp_target  = 16'hFFFF;
        rq.ramp_seconds = 16'd0;
        send_request(rq);
        repeat (2) send_request(make_request(REQ_TICK));

        // longest duration: the first step rounds to no change
        rq = make_request(REQ_RAMP);
        rq.new_value    = 16'd4095;
        rq.ramp_target  = 16'd0;
        rq.ramp_seconds = 16'hFFFF;
        send_request(rq);
        send_request(make_request(REQ_TICK));
    endtask

    // Sweep register settings, extremes first, with a random burst under each.
    task automatic test_register_settings();
        logic [LEVEL_W-1:0] lim;
        logic               fb;
        logic [CODE_W-1:0]  boot;
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: begin lim = 12'd0;    fb = 1'b0; boot = 3'd7; end
                1: begin lim = 12'd4095; fb = 1'b1; boot = 3'd0; end
                2: begin lim = 12'd1;    fb = 1'b1; boot = 3'd5; end
                3: begin lim = 12'd2048; fb = 1'b0; boot = 3'd2; end
                default: begin
                    lim  = LEVEL_W'($urandom_range(0, 4095));
                    fb   = 1'($urandom_range(0, 1));
                    boot = CODE_W'($urandom_range(0, 7));
                end
            endcase
            wait_idle();
            write_register(CFG_GAS_LIMIT, lim);
            write_register(CFG_FALLBACK_EN, {{(LEVEL_W-1){1'b0}}, fb});
            write_register(CFG_RESET_SOURCE, {{(LEVEL_W-CODE_W){1'b0}}, boot});
            settings_run++;
            // run one setting with no gaps and no stalls at all
            quiet_mode = (k == 3);
            run_random_burst(BURST_ITEMS);
        end
        quiet_mode = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_GAS_LIMIT;
        cfg_data      = '0;
        in_valid      = 1'b0;
        req_type      = REQ_TICK;
        sensor_sample = '0;
        pot_sample    = '0;
        loop_sample   = '0;
        dac_setpoint  = '0;
        new_value     = '0;
        ramp_target   = '0;
        ramp_seconds  = '0;
        source_code   = SRC_SENSOR;
        reset_model();

        // hold reset low, then release it on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_source_select();
        test_ramp_sequences();
        test_register_settings();

        // drain the last status beats, then watch a while for stray ones
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d request beats under %0d register settings.",
                 items_sent, settings_run);
        $display("Checked %0d status beats; %0d ramps ran to their end; %0d mismatches.",
                 results_seen, ramps_finished, mismatch_count);
        if (mismatch_count == 0 && pending_status.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
